>>> hdl/unf_pkg.sv
// ----------------------------------------------------------------------------
// unf_pkg
// Shared types and codes for the PNG scanline unfilter: channel beats,
// filter type codes and the per-byte operation passed between stages.
// ----------------------------------------------------------------------------
package unf_pkg;

  localparam int BPP_W  = 4;
  localparam int ROWB_W = 14;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       last_of_row;
    logic       bad_filter;
  } out_beat_t;

  typedef logic [2:0] filt_t;

  localparam filt_t FILT_NONE  = 3'd0;
  localparam filt_t FILT_SUB   = 3'd1;
  localparam filt_t FILT_UP    = 3'd2;
  localparam filt_t FILT_AVG   = 3'd3;
  localparam filt_t FILT_PAETH = 3'd4;

  typedef enum logic [1:0] {
    OP_FILTER,
    OP_DATA,
    OP_ERROR
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    filt_t      filt;
    logic       first_row;
    logic       last;
  } op_t;

endpackage

>>> hdl/unf_line_mem.sv
// ----------------------------------------------------------------------------
// unf_line_mem
// Previous-row line store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module unf_line_mem #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/unf_parse.sv
// ----------------------------------------------------------------------------
// unf_parse
// Stream parser: tracks filter bytes, column, first row and drop state,
// and turns each accepted byte into an operation plus a line store address.
// ----------------------------------------------------------------------------
module unf_parse
  import unf_pkg::*;
#(
  parameter int MAX_ROW_BYTES = 8192,
  parameter int ADDR_W        = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  in_beat_t          in_beat,
  input  logic [ROWB_W-1:0] row_bytes,
  output logic              op_valid,
  output op_t               op,
  output logic [ADDR_W-1:0] addr
);

  localparam int RB_W = $clog2(MAX_ROW_BYTES + 1);
  localparam int CW   = (RB_W > ROWB_W) ? RB_W : ROWB_W;

  logic [ADDR_W-1:0] col_r, col_nxt;
  filt_t             filt_r, filt_nxt;
  logic              await_r, await_nxt;
  logic              first_r, first_nxt;
  logic              drop_r, drop_nxt;

  logic [CW-1:0]     rb_ext;
  logic [CW-1:0]     rb_m1_ext;
  logic [ADDR_W-1:0] rb_m1;
  logic              last_c;
  logic [ADDR_W-1:0] x;
  logic              fs;
  logic              first_e, await_e, drop_e;

  // last column index of the row, register clamped to 1..MAX_ROW_BYTES
  always_comb begin
    rb_ext = CW'(row_bytes);
    if (rb_ext == '0) begin
      rb_m1_ext = '0;
    end else if (rb_ext > CW'(MAX_ROW_BYTES)) begin
      rb_m1_ext = CW'(MAX_ROW_BYTES - 1);
    end else begin
      rb_m1_ext = rb_ext - CW'(1);
    end
    rb_m1 = rb_m1_ext[ADDR_W-1:0];
  end

  assign last_c = (col_r >= rb_m1);
  assign x      = last_c ? rb_m1 : col_r;
  assign addr   = x;

  assign fs      = in_beat.frame_start;
  assign first_e = fs | first_r;
  assign await_e = fs | await_r;
  assign drop_e  = ~fs & drop_r;

  always_comb begin
    col_nxt      = col_r;
    filt_nxt     = filt_r;
    await_nxt    = await_r;
    first_nxt    = first_r;
    drop_nxt     = drop_r;
    op_valid     = 1'b0;
    op.kind      = OP_FILTER;
    op.data      = in_beat.data_byte;
    op.filt      = filt_r;
    op.first_row = first_e;
    op.last      = last_c;
    if (accept) begin
      first_nxt = first_e;
      await_nxt = await_e;
      drop_nxt  = drop_e;
      if (fs) begin
        col_nxt = '0;
      end
      if (!drop_e) begin
        op_valid = 1'b1;
        if (await_e) begin
          if (in_beat.data_byte > 8'(FILT_PAETH)) begin
            drop_nxt = 1'b1;
            op.kind  = OP_ERROR;
          end else begin
            filt_nxt  = in_beat.data_byte[2:0];
            await_nxt = 1'b0;
            col_nxt   = '0;
          end
        end else begin
          op.kind = OP_DATA;
          if (last_c) begin
            await_nxt = 1'b1;
            first_nxt = 1'b0;
            col_nxt   = '0;
          end else begin
            col_nxt = x + ADDR_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      filt_r  <= FILT_NONE;
      await_r <= 1'b1;
      first_r <= 1'b1;
      drop_r  <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      filt_r  <= filt_nxt;
      await_r <= await_nxt;
      first_r <= first_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

>>> hdl/unf_recon.sv
// ----------------------------------------------------------------------------
// unf_recon
// Reconstruction stage: takes line store read data, applies the row filter
// against the left/upper-left history, writes the byte back and feeds the
// output register.
// ----------------------------------------------------------------------------
module unf_recon
  import unf_pkg::*;
#(
  parameter int MAX_PIXEL_BYTES = 8,
  parameter int ADDR_W          = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_valid,
  input  op_t               op,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        rd_data,
  input  logic [BPP_W-1:0]  bpp,
  output logic              hold,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              out_valid,
  output out_beat_t         out_beat,
  input  logic              out_stall
);

  localparam int PB_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              fwd_r;
  logic [7:0]        fwd_data_r;
  logic [7:0]        left_r  [MAX_PIXEL_BYTES];
  logic [7:0]        above_r [MAX_PIXEL_BYTES];
  logic              out_valid_r;
  out_beat_t         out_beat_r;

  logic              can_take;
  logic              s1_go;
  logic [PB_W-1:0]   idx;
  logic [7:0]        a, b, c;
  logic [7:0]        pred;
  logic [7:0]        val;
  logic [8:0]        sum_ab;

  function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
                                       input logic [7:0] pa_c);
    logic signed [9:0] da, db, dc;
    logic [9:0]        pa, pb, pc;
    da = $signed({2'b00, pa_b}) - $signed({2'b00, pa_c});
    db = $signed({2'b00, pa_a}) - $signed({2'b00, pa_c});
    dc = $signed({2'b00, pa_a}) + $signed({2'b00, pa_b}) - $signed({1'b0, pa_c, 1'b0});
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return pa_a;
    end else if (pb <= pc) begin
      return pa_b;
    end
    return pa_c;
  endfunction

  assign can_take = ~out_valid_r | ~out_stall;
  assign s1_go    = s1_valid_r & ((s1_op_r.kind == OP_FILTER) | can_take);
  assign hold     = s1_valid_r & ~s1_go;

  // left neighbor distance, clamped to 1..MAX_PIXEL_BYTES
  always_comb begin
    if (bpp == '0) begin
      idx = '0;
    end else if (bpp > BPP_W'(MAX_PIXEL_BYTES)) begin
      idx = PB_W'(MAX_PIXEL_BYTES - 1);
    end else begin
      idx = PB_W'(bpp - BPP_W'(1));
    end
  end

  assign a = left_r[idx];
  assign c = above_r[idx];
  // same entry written by the previous byte as this one was read: take the forward
  assign b = s1_op_r.first_row ? 8'd0 : (fwd_r ? fwd_data_r : rd_data);
  assign sum_ab = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (s1_op_r.filt)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
  end

  assign val = s1_op_r.data + pred;

  assign wr_en   = s1_go & (s1_op_r.kind == OP_DATA);
  assign wr_addr = s1_addr_r;
  assign wr_data = val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!hold) begin
      s1_valid_r <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      s1_op_r    <= op;
      s1_addr_r  <= addr;
      fwd_r      <= wr_en & (wr_addr == addr);
      fwd_data_r <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i]  <= 8'd0;
        above_r[i] <= 8'd0;
      end
    end else if (s1_go) begin
      if (s1_op_r.kind == OP_FILTER) begin
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
          left_r[i]  <= 8'd0;
          above_r[i] <= 8'd0;
        end
      end else if (s1_op_r.kind == OP_DATA) begin
        for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
          left_r[i]  <= left_r[i-1];
          above_r[i] <= above_r[i-1];
        end
        left_r[0]  <= val;
        above_r[0] <= b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_take) begin
      out_valid_r <= s1_valid_r & (s1_op_r.kind != OP_FILTER);
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && s1_valid_r) begin
      if (s1_op_r.kind == OP_ERROR) begin
        out_beat_r.pixel_byte  <= 8'd0;
        out_beat_r.last_of_row <= 1'b0;
        out_beat_r.bad_filter  <= 1'b1;
      end else begin
        out_beat_r.pixel_byte  <= val;
        out_beat_r.last_of_row <= s1_op_r.last;
        out_beat_r.bad_filter  <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

>>> hdl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline filter reconstruction (none, sub, up, average, Paeth).
//
// Input: one decompressed stream byte per beat on in_valid/in_stall. Each
// row is a filter byte then row_bytes data bytes; frame_start on a beat
// marks the filter byte of a frame's first row and abandons any open row.
// Output: one beat per data byte (pixel_byte, last_of_row on the row's final
// byte); a filter code above 4 gives one bad_filter beat and the rest of the
// frame is dropped silently. Filter bytes give no beat.
// Throughput is one byte per cycle while the output is not stalled. The line
// store is read on the accept edge; the byte is then reconstructed, written
// back and loaded into the output register.
// When out_stall holds the output register, one more byte is taken into the
// reconstruct stage; after that in_stall rises until the output drains.
// Registers on the cfg_ APB port: 0x0 bytes_per_pixel, 0x4 row_bytes;
// write only while the block is idle. Reset clears the control state and
// restores the register defaults; the line store has no clearing pass.
// ----------------------------------------------------------------------------
module png_scanline_unfilter
  import unf_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_beat,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_beat,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

  localparam logic REG_BPP       = 1'b0;
  localparam logic REG_ROW_BYTES = 1'b1;

  localparam logic [BPP_W-1:0]  BPP_RESET       = 4'd4;
  localparam logic [ROWB_W-1:0] ROW_BYTES_RESET = 14'd8192;

  logic [BPP_W-1:0]  bpp_r;
  logic [ROWB_W-1:0] row_bytes_r;
  logic              cfg_wr;

  logic              accept;
  logic              hold;
  logic              op_valid;
  op_t               op;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r       <= BPP_RESET;
      row_bytes_r <= ROW_BYTES_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_BPP:       bpp_r       <= cfg_pwdata[BPP_W-1:0];
        REG_ROW_BYTES: row_bytes_r <= cfg_pwdata[ROWB_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_BPP:       cfg_prdata = 32'(bpp_r);
      REG_ROW_BYTES: cfg_prdata = 32'(row_bytes_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign in_stall = hold;
  assign accept   = in_valid & ~hold;

  unf_parse #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .ADDR_W       (ADDR_W)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_beat  (in_beat),
    .row_bytes(row_bytes_r),
    .op_valid (op_valid),
    .op       (op),
    .addr     (addr)
  );

  unf_line_mem #(
    .DEPTH (MAX_ROW_BYTES),
    .ADDR_W(ADDR_W)
  ) u_line_mem (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  unf_recon #(
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES),
    .ADDR_W         (ADDR_W)
  ) u_recon (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .addr     (addr),
    .rd_data  (rd_data),
    .bpp      (bpp_r),
    .hold     (hold),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .out_valid(out_valid),
    .out_beat (out_beat),
    .out_stall(out_stall)
  );

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for png_scanline_unfilter. A scoreboard rebuilds each
// scanline byte (none/sub/up/average/Paeth) from its own copy of the line
// store and history, then matches every output beat in order. Stimulus is a
// short directed pass followed by randomized frames: random geometry, filter
// errors, abandoned rows and mid-row register shrinks. The sender idles
// and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb
  import unf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_BPP  = 3'h0;
  localparam logic [2:0] REG_ROWB = 3'h4;

  // Rebuilds scanline bytes and holds the beats still owed by the block.
  class unfilter_scoreboard;
    localparam int DEPTH   = 8192;
    localparam int PIX_MAX = 8;

    logic [7:0]   line_mem [DEPTH];
    logic [7:0]   left_px [PIX_MAX];
    logic [7:0]   up_px [PIX_MAX];
    int unsigned  col;
    filt_t        row_filt;
    bit           want_filter;
    bit           top_row;
    bit           skipping;
    logic [3:0]   bpp_reg;
    logic [13:0]  rowb_reg;
    out_beat_t    pending_pixels [$];
    int           mismatches;
    int           pixels_seen;
    int           row_ends;
    int           filter_errors;

    function new();
      foreach (line_mem[i]) line_mem[i] = 8'h00;
      foreach (left_px[i]) begin
        left_px[i] = 8'h00;
        up_px[i] = 8'h00;
      end
      col = 0;
      row_filt = FILT_NONE;
      want_filter = 1'b1;
      top_row = 1'b1;
      skipping = 1'b0;
      bpp_reg = 4'd4;
      rowb_reg = 14'd8192;
    endfunction

    function int unsigned pix_step(int unsigned v);
      if (v == 0) return 1;
      if (v > PIX_MAX) return PIX_MAX;
      return v;
    endfunction

    function int unsigned row_len(int unsigned v);
      if (v == 0) return 1;
      if (v > DEPTH) return DEPTH;
      return v;
    endfunction

    function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int pa, pb, pc;
      pa = int'(b) - int'(c);
      pb = int'(a) - int'(c);
      pc = int'(a) + int'(b) - 2 * int'(c);
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
    endfunction

    function void note_byte(in_beat_t beat);
      int unsigned nbpp, nrb, x;
      logic [7:0]  a, b, c, pred, val;
      out_beat_t   res;
      if (beat.frame_start) begin
        top_row = 1'b1;
        want_filter = 1'b1;
        skipping = 1'b0;
        col = 0;
      end
      if (skipping) return;
      if (want_filter) begin
        if (beat.data_byte > FILT_PAETH) begin
          skipping = 1'b1;
          res = '{pixel_byte: 8'h00, last_of_row: 1'b0, bad_filter: 1'b1};
          pending_pixels.push_back(res);
          return;
        end
        row_filt = filt_t'(beat.data_byte);
        want_filter = 1'b0;
        col = 0;
        foreach (left_px[i]) begin
          left_px[i] = 8'h00;
          up_px[i] = 8'h00;
        end
        return;
      end
      nbpp = pix_step(bpp_reg);
      nrb = row_len(rowb_reg);
      x = (col >= nrb) ? nrb - 1 : col;
      a = left_px[nbpp-1];
      c = up_px[nbpp-1];
      b = top_row ? 8'h00 : line_mem[x];
      case (row_filt)
        FILT_SUB:   pred = a;
        FILT_UP:    pred = b;
        FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
        FILT_PAETH: pred = paeth_pick(a, b, c);
        default:    pred = 8'h00;
      endcase
      val = beat.data_byte + pred;
      line_mem[x] = val;
      for (int i = PIX_MAX - 1; i > 0; i--) begin
        left_px[i] = left_px[i-1];
        up_px[i] = up_px[i-1];
      end
      left_px[0] = val;
      up_px[0] = b;
      res = '{pixel_byte: val, last_of_row: (x + 1 >= nrb), bad_filter: 1'b0};
      if (res.last_of_row) begin
        want_filter = 1'b1;
        top_row = 1'b0;
        col = 0;
      end else begin
        col = x + 1;
      end
      pending_pixels.push_back(res);
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (got.bad_filter) begin
        filter_errors++;
      end else begin
        pixels_seen++;
        if (got.last_of_row) row_ends++;
      end
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat pixel_byte %02h last_of_row %0b bad_filter %0b",
                   $time, got.pixel_byte, got.last_of_row, got.bad_filter);
        return;
      end
      want = pending_pixels.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: pixel_byte exp %02h got %02h, last_of_row exp %0b got %0b, %s",
                   $time, want.pixel_byte, got.pixel_byte, want.last_of_row,
                   got.last_of_row, $sformatf("bad_filter exp %0b got %0b",
                   want.bad_filter, got.bad_filter));
      end
    endfunction
  endclass

  typedef enum int {HOLD_NONE, HOLD_LIGHT, HOLD_HEAVY, HOLD_PERIODIC} hold_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_beat = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_beat;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  unfilter_scoreboard sb = new();

  int         burst_left = 0;
  int         stream_items = 0;
  int         settings_used = 0;
  hold_mode_t hold_mode = HOLD_NONE;
  int         hold_left = 0;
  int         hold_tick = 0;

  png_scanline_unfilter u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_beat     (in_beat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_beat    (out_beat),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver back-pressure: switches between a few stall patterns.
  always @(posedge clk) begin
    if (hold_left == 0) begin
      hold_mode <= hold_mode_t'($urandom_range(0, 3));
      hold_left <= $urandom_range(40, 300);
    end else begin
      hold_left <= hold_left - 1;
    end
    hold_tick <= hold_tick + 1;
    case (hold_mode)
      HOLD_NONE:  out_stall <= 1'b0;
      HOLD_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      HOLD_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:    out_stall <= ((hold_tick % 7) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_beat);
      if (out_valid && !out_stall) sb.check_beat(out_beat);
    end
  end

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic cfg_write(input logic [2:0] addr, input int unsigned val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == REG_BPP) sb.bpp_reg = 4'(val);
    else sb.rowb_reg = 14'(val);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] d, input logic fs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 250)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_beat <= '{data_byte: d, frame_start: fs};
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off the sender until every owed beat is out, plus pipeline slack
  // for filter bytes that produce no beat.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_frame(input int rows, input bit noisy);
    int          kind, k;
    int unsigned len, shrink;
    filt_t       f;
    for (int r = 0; r < rows; r++) begin
      kind = noisy ? $urandom_range(0, 19) : 3;
      if (kind == 0) begin
        // bad filter code, then bytes the block should swallow
        send_byte(8'($urandom_range(FILT_PAETH + 1, 255)), r == 0);
        stream_items++;
        k = $urandom_range(0, 3);
        repeat (k) send_byte(pick_data(), 1'b0);
        stream_items += k;
        return;
      end
      f = filt_t'($urandom_range(FILT_NONE, FILT_PAETH));
      send_byte(8'(f), r == 0);
      stream_items++;
      len = sb.row_len(sb.rowb_reg);
      k = 0;
      while (k < len) begin
        if (k == len / 2 && k > 0) begin
          // leave the row open; next frame_start abandons it
          if (kind == 1) return;
          if (kind == 2) begin
            wait_idle();
            shrink = $urandom_range(0, len);
            cfg_write(REG_ROWB, shrink);
            cfg_write(REG_BPP, $urandom_range(0, 15));
            settings_used++;
            len = (k >= sb.row_len(shrink)) ? k + 1 : sb.row_len(shrink);
          end
        end
        send_byte(pick_data(), 1'b0);
        stream_items++;
        k++;
      end
    end
  endtask

  initial begin
    logic [7:0] dir_px [10];
    int         sel;
    dir_px = '{8'hFF, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h01, 8'h80, 8'hFF, 8'hFF, 8'h00};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every filter on 2-byte rows, bpp 0 behaves as 1.
    cfg_write(REG_BPP, 0);
    cfg_write(REG_ROWB, 2);
    settings_used++;
    for (int f = FILT_NONE; f <= FILT_PAETH; f++) begin
      send_byte(8'(f), f == FILT_NONE);
      send_byte(dir_px[2*f], 1'b0);
      send_byte(dir_px[2*f+1], 1'b0);
    end
    send_byte(8'(FILT_PAETH + 1), 1'b0);
    send_byte(8'(FILT_UP), 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'(FILT_AVG), 1'b1);
    send_byte(8'h7F, 1'b0);
    // frame_start lands mid-row; bpp 15 clamps to 8
    wait_idle();
    cfg_write(REG_BPP, 15);
    cfg_write(REG_ROWB, 4);
    settings_used++;
    send_byte(8'(FILT_SUB), 1'b1);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'hFF, 1'b0);
    // shrink the row past the current column: next beat closes the row
    wait_idle();
    cfg_write(REG_ROWB, 2);
    settings_used++;
    send_byte(8'h11, 1'b0);
    send_byte(8'(FILT_PAETH), 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    stream_items = 28;

    while (stream_items < 1000) begin
      wait_idle();
      sel = $urandom_range(0, 2);
      if (sel != 1) begin
        case ($urandom_range(0, 9))
          0:       cfg_write(REG_BPP, 0);
          1:       cfg_write(REG_BPP, $urandom_range(9, 15));
          default: cfg_write(REG_BPP, $urandom_range(1, 8));
        endcase
      end
      if (sel != 0) begin
        case ($urandom_range(0, 19))
          0:       cfg_write(REG_ROWB, 0);
          1:       cfg_write(REG_ROWB, $urandom_range(25, 300));
          2:       cfg_write(REG_ROWB, 1);
          default: cfg_write(REG_ROWB, $urandom_range(2, 24));
        endcase
      end
      settings_used++;
      repeat ($urandom_range(1, 3)) run_frame($urandom_range(1, 5), 1'b1);
    end

    // Oversized row_bytes clamps to the line store size: no row end this early.
    wait_idle();
    cfg_write(REG_ROWB, 16383);
    cfg_write(REG_BPP, 1);
    settings_used++;
    send_byte(8'(FILT_AVG), 1'b1);
    repeat (48) send_byte(pick_data(), 1'b0);
    stream_items += 49;

    in_valid <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 5000 && sb.pending_pixels.size() != 0; i++) @(posedge clk);
    if (sb.pending_pixels.size() != 0) begin
      sb.mismatches++;
      $display("%0d beats never arrived", sb.pending_pixels.size());
    end
    repeat (8) @(posedge clk);

    $display("ran %0d stream bytes over %0d register settings (bpp 0..15, row 0..16383)",
             stream_items, settings_used);
    $display("checked %0d pixel bytes, %0d row ends, %0d filter errors; %0d mismatches",
             sb.pixels_seen, sb.row_ends, sb.filter_errors, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("png_scanline_unfilter regression: pass");
    end else begin
      $display("png_scanline_unfilter regression: fail");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout with %0d beats outstanding", sb.pending_pixels.size());
    $display("png_scanline_unfilter regression: fail");
    $finish;
  end

endmodule
